[hw/rtl/ssa_pkg.sv]
package ssa_pkg;

  localparam int SAMPLE_W = 12;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int RATIO_W  = PROD_W - 9;
  localparam int DIFF_W   = 17;
  localparam int ANGLE_W  = 16;
  localparam int ACC_W    = 32;
  localparam int CW       = 28;
  localparam int PRE_SCALE = 8;
  localparam int TABLE_LEN = 24;
  localparam int TIDX_W   = 5;
  localparam int IDX_W    = 4;

  localparam logic [ANGLE_W-1:0] TURN_Q7 = 16'd46080;

  localparam logic [IDX_W-1:0] REG_GAIN_POS_X = 4'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_POS_Y = 4'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_NEG_X = 4'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_NEG_Y = 4'd3;

  localparam logic [GAIN_W-1:0] RST_GAIN_POS_X = 16'd5432;
  localparam logic [GAIN_W-1:0] RST_GAIN_POS_Y = 16'd5311;
  localparam logic [GAIN_W-1:0] RST_GAIN_NEG_X = 16'd5601;
  localparam logic [GAIN_W-1:0] RST_GAIN_NEG_Y = 16'd5515;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } diff_t;

  function automatic logic [ACC_W-1:0] atan_turn(input logic [TIDX_W-1:0] i);
    logic [ACC_W-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10680862;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/ssa_in_if.sv]
interface ssa_in_if;
  logic                          valid;
  logic                          ready;
  logic [ssa_pkg::SAMPLE_W-1:0]  sample_pos_x;
  logic [ssa_pkg::SAMPLE_W-1:0]  sample_pos_y;
  logic [ssa_pkg::SAMPLE_W-1:0]  sample_neg_x;
  logic [ssa_pkg::SAMPLE_W-1:0]  sample_neg_y;

  modport source (output valid, sample_pos_x, sample_pos_y, sample_neg_x, sample_neg_y,
                  input ready);
  modport sink (input valid, sample_pos_x, sample_pos_y, sample_neg_x, sample_neg_y,
                output ready);
endinterface

[hw/rtl/ssa_out_if.sv]
interface ssa_out_if;
  logic                               valid;
  logic                               ready;
  logic [ssa_pkg::ANGLE_W-1:0]        angle_deg;
  logic signed [ssa_pkg::DIFF_W-1:0]  diff_x;
  logic signed [ssa_pkg::DIFF_W-1:0]  diff_y;

  modport source (output valid, angle_deg, diff_x, diff_y, input ready);
  modport sink (input valid, angle_deg, diff_x, diff_y, output ready);
endinterface

[hw/rtl/ssa_front.sv]
module ssa_front #(
  parameter int ADC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ssa_in_if.sink                      in_ch,
  input  logic                        cfg_we,
  input  logic [ssa_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ssa_pkg::GAIN_W-1:0]  cfg_data,
  input  logic                        fifo_full,
  output logic                        fifo_push,
  output ssa_pkg::diff_t              fifo_wdata
);

  localparam int MASK_BITS = (ADC_BITS < ssa_pkg::SAMPLE_W) ? ADC_BITS : ssa_pkg::SAMPLE_W;
  localparam logic [ssa_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
    ssa_pkg::SAMPLE_W'((64'd1 << MASK_BITS) - 64'd1);

  logic [ssa_pkg::GAIN_W-1:0] gain_px_r, gain_py_r, gain_nx_r, gain_ny_r;
  logic [ssa_pkg::PROD_W-1:0] prod_px_r, prod_py_r, prod_nx_r, prod_ny_r;
  logic                       a_valid_r, a_valid_nxt;
  logic                       accept;
  logic signed [ssa_pkg::RATIO_W:0] raw_dx, raw_dy;

  function automatic logic signed [ssa_pkg::DIFF_W-1:0] clamp_unit(
    input logic signed [ssa_pkg::RATIO_W:0] v);
    logic signed [ssa_pkg::DIFF_W-1:0] r;
    if (v > (ssa_pkg::RATIO_W+1)'(32768))
      r = ssa_pkg::DIFF_W'(32768);
    else if (v < -(ssa_pkg::RATIO_W+1)'(32768))
      r = -ssa_pkg::DIFF_W'(32768);
    else
      r = v[ssa_pkg::DIFF_W-1:0];
    return r;
  endfunction

  assign fifo_push   = a_valid_r && !fifo_full;
  assign in_ch.ready = !a_valid_r || !fifo_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign a_valid_nxt = accept || (a_valid_r && !fifo_push);

  always_comb begin
    raw_dx = $signed({1'b0, prod_px_r[ssa_pkg::PROD_W-1:9]}) -
             $signed({1'b0, prod_nx_r[ssa_pkg::PROD_W-1:9]});
    raw_dy = $signed({1'b0, prod_py_r[ssa_pkg::PROD_W-1:9]}) -
             $signed({1'b0, prod_ny_r[ssa_pkg::PROD_W-1:9]});
    fifo_wdata.dx = clamp_unit(raw_dx);
    fifo_wdata.dy = clamp_unit(raw_dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_px_r <= ssa_pkg::RST_GAIN_POS_X;
      gain_py_r <= ssa_pkg::RST_GAIN_POS_Y;
      gain_nx_r <= ssa_pkg::RST_GAIN_NEG_X;
      gain_ny_r <= ssa_pkg::RST_GAIN_NEG_Y;
    end else if (cfg_we) begin
      case (cfg_index)
        ssa_pkg::REG_GAIN_POS_X: gain_px_r <= cfg_data;
        ssa_pkg::REG_GAIN_POS_Y: gain_py_r <= cfg_data;
        ssa_pkg::REG_GAIN_NEG_X: gain_nx_r <= cfg_data;
        ssa_pkg::REG_GAIN_NEG_Y: gain_ny_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_px_r <= ssa_pkg::PROD_W'(in_ch.sample_pos_x & SAMPLE_MASK) *
                   ssa_pkg::PROD_W'(gain_px_r);
      prod_py_r <= ssa_pkg::PROD_W'(in_ch.sample_pos_y & SAMPLE_MASK) *
                   ssa_pkg::PROD_W'(gain_py_r);
      prod_nx_r <= ssa_pkg::PROD_W'(in_ch.sample_neg_x & SAMPLE_MASK) *
                   ssa_pkg::PROD_W'(gain_nx_r);
      prod_ny_r <= ssa_pkg::PROD_W'(in_ch.sample_neg_y & SAMPLE_MASK) *
                   ssa_pkg::PROD_W'(gain_ny_r);
    end
  end

endmodule

[hw/rtl/ssa_fifo.sv]
module ssa_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ssa_pkg::diff_t  wdata,
  input  logic            pop,
  output ssa_pkg::diff_t  rdata,
  output logic            full,
  output logic            empty
);

  ssa_pkg::diff_t mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hw/rtl/ssa_cordic.sv]
module ssa_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fifo_empty,
  input  ssa_pkg::diff_t  fifo_rdata,
  output logic            fifo_pop,
  ssa_out_if.source       out_ch
);

  localparam int ITER_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STAGES - 1);
  localparam int PROD_W = ssa_pkg::ACC_W + ssa_pkg::ANGLE_W;

  typedef enum logic [1:0] {S_IDLE, S_ROT, S_MUL, S_FIN} state_t;

  state_t                            state_r;
  logic signed [ssa_pkg::CW-1:0]     x_r, y_r;
  logic [ssa_pkg::ACC_W-1:0]         acc_r;
  logic [ITER_W-1:0]                 iter_r;
  logic                              zero_r;
  logic signed [ssa_pkg::DIFF_W-1:0] dx_r, dy_r;
  logic [PROD_W-1:0]                 prod_r;
  logic                              out_valid_r, out_valid_nxt;
  logic [ssa_pkg::ANGLE_W-1:0]       angle_r;
  logic signed [ssa_pkg::DIFF_W-1:0] out_dx_r, out_dy_r;

  logic signed [ssa_pkg::CW-1:0]     x_ld, y_ld, xs, ys;
  logic                              x_neg;
  logic [ssa_pkg::ACC_W-1:0]         step_ang;
  logic [PROD_W:0]                   rounded;
  logic [PROD_W-ssa_pkg::ACC_W:0]    deg;
  logic                              slot_free;

  assign fifo_pop  = (state_r == S_IDLE) && !fifo_empty;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = ((state_r == S_FIN) && slot_free) ||
                         (out_valid_r && !out_ch.ready);

  always_comb begin
    x_ld  = ssa_pkg::CW'(fifo_rdata.dx) <<< ssa_pkg::PRE_SCALE;
    y_ld  = ssa_pkg::CW'(fifo_rdata.dy) <<< ssa_pkg::PRE_SCALE;
    x_neg = fifo_rdata.dx[ssa_pkg::DIFF_W-1];
    if (x_neg) begin
      x_ld = -x_ld;
      y_ld = -y_ld;
    end
    xs       = x_r >>> iter_r;
    ys       = y_r >>> iter_r;
    step_ang = ssa_pkg::atan_turn(ssa_pkg::TIDX_W'(iter_r));
    rounded  = {1'b0, prod_r} + (PROD_W+1)'(64'h8000_0000);
    deg      = rounded[PROD_W:ssa_pkg::ACC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (!fifo_empty) begin
            x_r     <= x_ld;
            y_r     <= y_ld;
            acc_r   <= x_neg ? 32'h8000_0000 : 32'h0;
            zero_r  <= (fifo_rdata.dx == '0) && (fifo_rdata.dy == '0);
            dx_r    <= fifo_rdata.dx;
            dy_r    <= fifo_rdata.dy;
            iter_r  <= '0;
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          if (!y_r[ssa_pkg::CW-1]) begin
            x_r   <= x_r + ys;
            y_r   <= y_r - xs;
            acc_r <= acc_r + step_ang;
          end else begin
            x_r   <= x_r - ys;
            y_r   <= y_r + xs;
            acc_r <= acc_r - step_ang;
          end
          iter_r <= iter_r + 1'b1;
          if (iter_r == LAST_ITER) state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PROD_W'(acc_r) * PROD_W'(ssa_pkg::TURN_Q7);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            if (zero_r || (deg >= (PROD_W-ssa_pkg::ACC_W+1)'(ssa_pkg::TURN_Q7)))
              angle_r <= '0;
            else
              angle_r <= deg[ssa_pkg::ANGLE_W-1:0];
            out_dx_r    <= dx_r;
            out_dy_r    <= dy_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.angle_deg = angle_r;
  assign out_ch.diff_x    = out_dx_r;
  assign out_ch.diff_y    = out_dy_r;

  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> (32'(iter_r) < CORDIC_STAGES))
    else $error("iteration count past last stage");

  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> !x_r[ssa_pkg::CW-1])
    else $error("rotated x went negative");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (angle_r < ssa_pkg::TURN_Q7))
    else $error("angle not wrapped below one turn");

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && slot_free && zero_r) |=> (angle_r == '0))
    else $error("zero vector gave nonzero angle");

endmodule

[hw/rtl/sun_sensor_azimuth_core.sv]
// Sun azimuth from four face photodiodes (+X, +Y, -X, -Y).
// in_ch: one transaction carries the four raw ADC samples. Each is scaled
//   by its face gain to a Q1.15 ratio; x and y differences are clamped to +/-1.0.
// out_ch: one transaction per input: azimuth in unsigned Q9.7 degrees
//   (0 to under 360) and the two clamped differences.
// cfg_*: gain writes, index 0..3 = +X, +Y, -X, -Y; other indexes are dropped.
//   Write only while the block is idle.
// Path: an input transaction is registered in the scaling front end, queued,
//   rotated (S_ROT), scaled to degrees (S_MUL) and registered to out_ch (S_FIN).
// Throughput is set by the single shared CORDIC rotator, which works on one
//   transaction at a time, one micro-rotation per cycle.
// The scaling front end and a two-entry queue take up to three further
//   inputs while the rotator is busy; in_ch.ready drops once they are full.
// Output stall: out_ch holds its transaction; the rotator holds a finished
//   result until the output register frees, then the queue backs up.
// Reset (rst_n low, synchronous): gains return to defaults, queue and output empty.
module sun_sensor_azimuth_core #(
  parameter int ADC_BITS      = 12,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ssa_in_if.sink                      in_ch,
  ssa_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [ssa_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ssa_pkg::GAIN_W-1:0]  cfg_data
);

  logic           fifo_push, fifo_pop, fifo_full, fifo_empty;
  ssa_pkg::diff_t fifo_wdata, fifo_rdata;

  ssa_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fifo_full  (fifo_full),
    .fifo_push  (fifo_push),
    .fifo_wdata (fifo_wdata)
  );

  ssa_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .wdata (fifo_wdata),
    .pop   (fifo_pop),
    .rdata (fifo_rdata),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  ssa_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_rdata (fifo_rdata),
    .fifo_pop   (fifo_pop),
    .out_ch     (out_ch)
  );

endmodule
